>>> src/vad_pkg.sv
// Shared constants and types for the vector angle pipeline.
package vad_pkg;

	localparam int COORD_WIDTH = 16;              // usable coordinate width, 2..21
	localparam int IN_W        = 16;              // width of the coordinate fields
	localparam int MAG_W       = COORD_WIDTH;     // magnitude incl. most negative value
	localparam int FRAC_BITS   = 10;
	localparam int Q_W         = FRAC_BITS + 1;   // ratio 0..1024
	localparam int DIV_STAGES  = Q_W;             // one quotient bit per stage
	localparam int ARC_BASE    = 45 * 1024;
	localparam int ARC_SLOPE   = 16026;
	localparam int K_W         = 15;              // (ARC_SLOPE * r) >> FRAC_BITS
	localparam int P1_W        = K_W + FRAC_BITS;
	localparam int SUM_W       = 16;              // ARC_BASE + ARC_SLOPE - k
	localparam int P2_W        = Q_W + SUM_W;
	localparam int DEG_W       = P2_W - 2 * FRAC_BITS;
	localparam int ANG_W       = 9;
	localparam int ACC_W       = 10;              // signed unfold range -90..270
	localparam int RIGHT_ANGLE = 90;
	localparam int HALF_TURN   = 180;
	localparam int FULL_TURN   = 360;
	localparam int R_MAX       = 1 << FRAC_BITS;

	typedef logic signed [IN_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]       mag_t;
	typedef logic [MAG_W:0]         rem_t;
	typedef logic [Q_W-1:0]         quo_t;
	typedef logic [DEG_W-1:0]       deg_t;
	typedef logic [ANG_W-1:0]       angle_t;

	// octant and quadrant flags carried down the pipe
	typedef struct packed {
		logic sx;
		logic sy;
		logic steep;
		logic zero;
	} oct_t;

	typedef struct packed {
		oct_t oct;
		rem_t rem;
		mag_t divisor;
		quo_t quo;
	} divst_t;

	typedef struct packed {
		oct_t oct;
		deg_t deg;
	} arcst_t;

endpackage

>>> src/vad_coord_if.sv
// Input channel: one coordinate pair per request.
interface vad_coord_if;
	import vad_pkg::*;

	logic   valid;
	logic   ready;
	coord_t x_coord;
	coord_t y_coord;

	modport source (output valid, output x_coord, output y_coord, input ready);
	modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

>>> src/vad_angle_if.sv
// Output channel: one angle per request.
interface vad_angle_if;
	import vad_pkg::*;

	logic   valid;
	logic   ready;
	angle_t angle_degrees;

	modport source (output valid, output angle_degrees, input ready);
	modport sink   (input valid, input angle_degrees, output ready);
endinterface

>>> src/vad_fold.sv
// Front stage: width reduction, absolute values and octant fold.
module vad_fold (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vad_pkg::coord_t x_coord,
	input  vad_pkg::coord_t y_coord,
	output logic            out_valid,
	input  logic            out_ready,
	output vad_pkg::divst_t out_data
);
	import vad_pkg::*;

	logic signed [COORD_WIDTH-1:0] xc;
	logic signed [COORD_WIDTH-1:0] yc;
	mag_t   mx;
	mag_t   my;
	divst_t nxt;
	logic   vld_s1;
	divst_t dat_s1;

	// size cast sign-extends or keeps the low bits
	assign xc = COORD_WIDTH'(x_coord);
	assign yc = COORD_WIDTH'(y_coord);
	// most negative value comes out as 2^(W-1) read unsigned
	assign mx = xc[COORD_WIDTH-1] ? mag_t'(-xc) : mag_t'(xc);
	assign my = yc[COORD_WIDTH-1] ? mag_t'(-yc) : mag_t'(yc);

	always_comb begin
		nxt.oct.sx    = xc[COORD_WIDTH-1];
		nxt.oct.sy    = yc[COORD_WIDTH-1];
		nxt.oct.steep = my > mx;
		nxt.oct.zero  = (mx == '0) && (my == '0);
		nxt.divisor   = (my > mx) ? my : mx;
		nxt.rem       = {1'b0, ((my > mx) ? mx : my)};
		nxt.quo       = '0;
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;
endmodule

>>> src/vad_div_step.sv
// One restoring division step: settles one quotient bit.
module vad_div_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vad_pkg::divst_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vad_pkg::divst_t out_data
);
	import vad_pkg::*;

	logic   ge;
	rem_t   diff;
	divst_t nxt;
	logic   vld_s1;
	divst_t dat_s1;

	assign ge   = in_data.rem >= {1'b0, in_data.divisor};
	assign diff = ge ? (in_data.rem - {1'b0, in_data.divisor}) : in_data.rem;

	always_comb begin
		nxt       = in_data;
		// remainder is below the divisor here, so the shift cannot lose a bit
		nxt.rem   = {diff[MAG_W-1:0], 1'b0};
		nxt.quo   = {in_data.quo[Q_W-2:0], ge};
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dat_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data  = dat_s1;
endmodule

>>> src/vad_arctan.sv
// Polynomial arctangent of the octant ratio, two multiplier stages.
module vad_arctan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vad_pkg::divst_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vad_pkg::arcst_t out_data
);
	import vad_pkg::*;

	logic [P1_W-1:0]  prod1;
	logic [SUM_W-1:0] sum;
	logic [P2_W-1:0]  prod2;
	logic             ready_s2;

	logic             vld_s1;
	oct_t             oct_s1;
	quo_t             r_s1;
	logic [K_W-1:0]   k_s1;

	logic             vld_s2;
	arcst_t           dat_s2;

	// stage 1: k = (slope * r) >> 10
	assign prod1 = P1_W'(ARC_SLOPE) * P1_W'(in_data.quo);

	// stage 2: r * (base + slope - k) in 1/1024^2 degrees
	assign sum   = SUM_W'(ARC_BASE + ARC_SLOPE) - SUM_W'(k_s1);
	assign prod2 = P2_W'(r_s1) * P2_W'(sum);

	assign ready_s2 = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (ready_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			oct_s1 <= in_data.oct;
			r_s1   <= in_data.quo;
			k_s1   <= prod1[P1_W-1:FRAC_BITS];
		end
		if (vld_s1 && ready_s2) begin
			dat_s2.oct <= oct_s1;
			dat_s2.deg <= prod2[P2_W-1:2*FRAC_BITS];
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = dat_s2;
endmodule

>>> src/vad_unfold.sv
// Output stage: octant and quadrant unfold, wrap to 0..359.
module vad_unfold (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vad_pkg::arcst_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output vad_pkg::angle_t angle_degrees
);
	import vad_pkg::*;

	logic signed [ACC_W-1:0] a_oct;
	logic signed [ACC_W-1:0] a_y;
	logic signed [ACC_W-1:0] a_x;
	angle_t                  nxt;
	logic                    vld_s1;
	angle_t                  ang_s1;

	always_comb begin
		a_oct = in_data.oct.steep ? (ACC_W'(RIGHT_ANGLE) - ACC_W'(in_data.deg))
		                          : ACC_W'(in_data.deg);
		a_y   = in_data.oct.sy ? -a_oct : a_oct;
		a_x   = in_data.oct.sx ? (ACC_W'(HALF_TURN) - a_y) : a_y;
		if (in_data.oct.zero) begin
			nxt = '0;
		end else if (a_x < 0) begin
			nxt = ANG_W'(a_x + ACC_W'(FULL_TURN));
		end else begin
			nxt = ANG_W'(a_x);
		end
	end

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ang_s1 <= nxt;
		end
	end

	assign out_valid     = vld_s1;
	assign angle_degrees = ang_s1;
endmodule

>>> src/vector_angle_degrees.sv
// Top level: vector angle in whole degrees, fully pipelined.
//
//   channel  dir  payload                      transfer
//   coord    in   x_coord[15:0], y_coord[15:0]  valid && ready
//   angle    out  angle_degrees[8:0]            valid && ready
//
// One request per cycle sustained while the angle channel accepts; the stages in order
// are fold, divider, arctangent and unfold. The divider settles one quotient bit per stage.
// Reset clears only the stage valid bits. Every stage holds when its
// successor is full and stalled, so bubbles are squeezed out and an output
// stall backs up one stage at a time.
module vector_angle_degrees (
	input logic        clk,
	input logic        arst_n,
	vad_coord_if.sink  coord,
	vad_angle_if.source angle
);
	import vad_pkg::*;

	logic   div_v [0:DIV_STAGES];
	logic   div_r [0:DIV_STAGES];
	divst_t div_d [0:DIV_STAGES];
	logic   arc_v;
	logic   arc_r;
	arcst_t arc_d;

	vad_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coord.valid),
		.in_ready  (coord.ready),
		.x_coord   (coord.x_coord),
		.y_coord   (coord.y_coord),
		.out_valid (div_v[0]),
		.out_ready (div_r[0]),
		.out_data  (div_d[0])
	);

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		vad_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_v[i]),
			.in_ready  (div_r[i]),
			.in_data   (div_d[i]),
			.out_valid (div_v[i+1]),
			.out_ready (div_r[i+1]),
			.out_data  (div_d[i+1])
		);
	end

	vad_arctan u_arctan (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_v[DIV_STAGES]),
		.in_ready  (div_r[DIV_STAGES]),
		.in_data   (div_d[DIV_STAGES]),
		.out_valid (arc_v),
		.out_ready (arc_r),
		.out_data  (arc_d)
	);

	vad_unfold u_unfold (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (arc_v),
		.in_ready      (arc_r),
		.in_data       (arc_d),
		.out_valid     (angle.valid),
		.out_ready     (angle.ready),
		.angle_degrees (angle.angle_degrees)
	);

`ifndef SYNTHESIS
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		angle.valid |-> angle.angle_degrees < ANG_W'(FULL_TURN))
		else $error("angle out of range");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_v[DIV_STAGES] && !div_d[DIV_STAGES].oct.zero
			|-> div_d[DIV_STAGES].quo <= Q_W'(R_MAX))
		else $error("octant ratio above one");

	a_front_free: assert property (@(posedge clk) disable iff (!arst_n)
		!div_v[0] |-> coord.ready)
		else $error("input blocked with empty front stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		arc_v && !arc_r |=> arc_v && $stable(arc_d))
		else $error("arctangent stage lost data in a stall");
`endif
endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Testbench for vector_angle_degrees: random and corner vectors checked against a predictor.
module tb;
	import vad_pkg::*;

	localparam int PIPE_LAT    = 15;
	localparam int STALL_LIMIT = 5000;
	localparam int RAND_ITEMS  = 1800;
	localparam int HOLD_AFTER  = 500;   // results seen before the long output hold-off
	localparam int HOLD_CYCLES = 400;
	localparam int N_DIR       = 23;

	class angle_scoreboard;
		angle_t pending[$];
		int     errors;

		function new();
			errors = 0;
		endfunction

		// sign-extend to the usable coordinate width
		function automatic longint coord_value(coord_t c);
			longint v;
			v = longint'(c);
			if (COORD_WIDTH < IN_W)
				v = (v <<< (64 - COORD_WIDTH)) >>> (64 - COORD_WIDTH);
			return v;
		endfunction

		// arctangent of r/1024 in 1/1024 degree
		function automatic longint octant_arc(longint r);
			longint k;
			k = (longint'(ARC_SLOPE) * r) >>> FRAC_BITS;
			return (r * (longint'(ARC_BASE) + ARC_SLOPE - k)) >>> FRAC_BITS;
		endfunction

		function automatic angle_t predict_angle(coord_t xc, coord_t yc);
			longint x, y, mx, my, ang;
			x  = coord_value(xc);
			y  = coord_value(yc);
			mx = (x >= 0) ? x : -x;
			my = (y >= 0) ? y : -y;
			if (mx == 0 && my == 0)
				return '0;
			// diagonal stays in the shallow branch
			if (mx >= my)
				ang = octant_arc((my <<< FRAC_BITS) / mx) >>> FRAC_BITS;
			else
				ang = RIGHT_ANGLE - (octant_arc((mx <<< FRAC_BITS) / my) >>> FRAC_BITS);
			if (y < 0)
				ang = -ang;
			if (x < 0)
				ang = HALF_TURN - ang;
			ang = ((ang % FULL_TURN) + FULL_TURN) % FULL_TURN;
			return angle_t'(ang);
		endfunction

		function void note_request(coord_t x, coord_t y);
			pending.push_back(predict_angle(x, y));
		endfunction

		function void check_angle(angle_t got);
			angle_t want;
			if (pending.size() == 0) begin
				$error("angle_degrees: no request pending, got %0d", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				$error("angle_degrees: expected %0d, got %0d", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	vad_coord_if coord_ch ();
	vad_angle_if angle_ch ();

	vector_angle_degrees dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coord  (coord_ch),
		.angle  (angle_ch)
	);

	angle_scoreboard sb = new();
	int results_seen = 0;
	int sent = 0;

	coord_t dir_x [N_DIR] = '{0, 32767, -32768, 0, 0, 32767, -32768, -32768, 32767, 1, -1,
		1, 0, -1, 100, -100, 1, -3, 32767, 1, -32768, 12345, -20000};
	coord_t dir_y [N_DIR] = '{0, 0, 0, 32767, -32768, 32767, -32768, 32767, -32768, 1, -1,
		0, -1, 0, -100, 100, 2, 7, 1, -32768, -1, -23456, 9999};

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_coord(input coord_t x, input coord_t y);
		int gap;
		gap = ((sent / 150) % 4 == 3) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			coord_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		coord_ch.valid   <= 1'b1;
		coord_ch.x_coord <= x;
		coord_ch.y_coord <= y;
		@(posedge clk);
		while (!coord_ch.ready) @(posedge clk);
		sb.note_request(x, y);
		sent++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && angle_ch.valid && angle_ch.ready) begin
			sb.check_angle(angle_ch.angle_degrees);
			results_seen++;
		end
	end

	initial begin : drain
		int  w;
		bit  held;
		held = 1'b0;
		angle_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && results_seen >= HOLD_AFTER) begin
				// long output stall so the pipe fills and backs up the input
				held = 1'b1;
				w = HOLD_CYCLES;
			end else begin
				w = ((results_seen / 170) % 4 == 2) ? 0 : $urandom_range(0, 8);
			end
			if (w > 0) begin
				angle_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			angle_ch.ready <= 1'b1;
			@(posedge clk);
			while (!angle_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((coord_ch.valid && coord_ch.ready) || (angle_ch.valid && angle_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stim
		coord_t x, y;
		int     kind, b, d;
		coord_ch.valid   = 1'b0;
		coord_ch.x_coord = '0;
		coord_ch.y_coord = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corners: zero vector, axes, extremes, diagonals, steep octant
		for (int i = 0; i < N_DIR; i++)
			send_coord(dir_x[i], dir_y[i]);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				x = coord_t'($urandom);
				y = coord_t'($urandom);
			end else if (kind < 55) begin
				x = coord_t'(int'($urandom_range(0, 32)) - 16);
				y = coord_t'(int'($urandom_range(0, 32)) - 16);
			end else if (kind < 70) begin
				// near the diagonal
				b = $urandom_range(0, 32767);
				d = int'($urandom_range(0, 6)) - 3;
				x = coord_t'($urandom_range(0, 1) ? -b : b);
				y = coord_t'($urandom_range(0, 1) ? -(b + d) : (b + d));
			end else if (kind < 80) begin
				b = $urandom_range(0, 3);
				x = coord_t'((b == 0) ? 0 : (b == 1) ? -32768 : (b == 2) ? 32767 : $urandom);
				y = coord_t'(($urandom_range(0, 1)) ? 0 : $urandom);
				if ($urandom_range(0, 1)) begin
					d = x;
					x = y;
					y = coord_t'(d);
				end
			end else begin
				// one large, one small component
				b = $urandom_range(1024, 32767);
				d = $urandom_range(0, 64);
				x = coord_t'($urandom_range(0, 1) ? -b : b);
				y = coord_t'($urandom_range(0, 1) ? -d : d);
				if ($urandom_range(0, 1)) begin
					d = x;
					x = y;
					y = coord_t'(d);
				end
			end
			send_coord(x, y);
		end
		coord_ch.valid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * PIPE_LAT) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> vector_angle_degrees.f
src/vad_pkg.sv
src/vad_coord_if.sv
src/vad_angle_if.sv
src/vad_fold.sv
src/vad_div_step.sv
src/vad_arctan.sv
src/vad_unfold.sv
src/vector_angle_degrees.sv
sim/tb.sv
